>>> hw/rtl/orb_pkg.sv
package orb_pkg;

    localparam int DEPTH_DEFAULT        = 256;
    localparam int ELEMENT_BITS_DEFAULT = 64;

    localparam int CMD_BITS    = 3;
    localparam int DATA_BITS   = 64;
    localparam int AMOUNT_BITS = 9;
    localparam int FILL_BITS   = 9;
    localparam int STATUS_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_PUT     = 3'd1,
        CMD_GET     = 3'd2,
        CMD_COMPARE = 3'd3,
        CMD_SKIP    = 3'd4,
        CMD_KEEP    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK        = 2'd0,
        STS_OVERWRITE = 2'd1,
        STS_REFUSED   = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // capture: latch the input beat and read the head entry
    // commit: update pointers, write the store, load the result register
    typedef struct packed {
        logic capture;
        logic commit;
    } orb_cmd_t;

endpackage

>>> hw/rtl/orb_ctrl.sv
module orb_ctrl
    import orb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output orb_cmd_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
            end
            ST_EXEC:
            begin
                ctrl.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/orb_datapath.sv
module orb_datapath
    import orb_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  orb_cmd_t               ctrl,
    input  logic [CMD_BITS-1:0]    command,
    input  logic [DATA_BITS-1:0]   element_data,
    input  logic [AMOUNT_BITS-1:0] amount,
    output logic [STATUS_BITS-1:0] status,
    output logic [DATA_BITS-1:0]   read_data,
    output logic                   matched,
    output logic [FILL_BITS-1:0]   fill_level,
    output logic                   is_empty,
    output logic                   is_full
);

    localparam int HW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int WW   = CW + 1;
    localparam int CMPW = (CW > AMOUNT_BITS) ? CW : AMOUNT_BITS;
    localparam int OUTW = (CMPW > FILL_BITS) ? CMPW : FILL_BITS;

    logic [ELEMENT_BITS-1:0] mem [DEPTH];

    logic [CMD_BITS-1:0]     cmd_reg;
    logic [ELEMENT_BITS-1:0] elem_reg;
    logic [AMOUNT_BITS-1:0]  amt_reg;
    logic [ELEMENT_BITS-1:0] rd_data_reg;

    logic [HW-1:0] head_reg;
    logic [HW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [STATUS_BITS-1:0]  status_reg;
    logic [STATUS_BITS-1:0]  status_next;
    logic [ELEMENT_BITS-1:0] rdata_reg;
    logic [ELEMENT_BITS-1:0] rdata_next;
    logic                    matched_reg;
    logic                    matched_next;
    logic [CW-1:0]           fill_reg;
    logic                    empty_reg;
    logic                    full_reg;

    logic            wr_en;
    logic [HW-1:0]   wr_addr;
    logic [CW-1:0]   step;
    logic [WW-1:0]   wrap_sum;
    logic [HW-1:0]   head_step;
    logic [CMPW-1:0] amt_ext;
    logic [CMPW-1:0] count_ext;
    logic            too_many;
    logic [CW-1:0]   amt_c;
    logic [WW-1:0]   put_sum;
    logic [OUTW-1:0] fill_ext;

    // one shared modulo-DEPTH adder for every head move
    assign wrap_sum  = WW'(head_reg) + WW'(step);
    assign head_step = (wrap_sum >= WW'(DEPTH)) ? HW'(wrap_sum - WW'(DEPTH))
                                                : HW'(wrap_sum);

    assign put_sum = WW'(head_reg) + WW'(count_reg);
    assign wr_addr = (put_sum >= WW'(DEPTH)) ? HW'(put_sum - WW'(DEPTH))
                                             : HW'(put_sum);

    assign amt_ext   = CMPW'(amt_reg);
    assign count_ext = CMPW'(count_reg);
    assign too_many  = amt_ext > count_ext;
    assign amt_c     = CW'(amt_ext);

    always_comb
    begin
        step         = '0;
        head_next    = head_reg;
        count_next   = count_reg;
        status_next  = STS_OK;
        rdata_next   = '0;
        matched_next = 1'b0;
        wr_en        = 1'b0;
        case (cmd_reg)
            CMD_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            CMD_PUT:
            begin
                wr_en = 1'b1;
                step  = CW'(1);
                if (count_reg == CW'(DEPTH))
                begin
                    head_next   = head_step;
                    status_next = STS_OVERWRITE;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_GET:
            begin
                step = CW'(1);
                if (count_reg == '0)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    rdata_next = rd_data_reg;
                    head_next  = head_step;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_COMPARE:
            begin
                step = CW'(1);
                if (count_reg == '0)
                begin
                    status_next = STS_EMPTY;
                end
                else if (rd_data_reg == elem_reg)
                begin
                    head_next    = head_step;
                    count_next   = count_reg - CW'(1);
                    matched_next = 1'b1;
                end
            end
            CMD_SKIP:
            begin
                step = amt_c;
                if (too_many)
                begin
                    status_next = STS_REFUSED;
                end
                else
                begin
                    head_next  = head_step;
                    count_next = count_reg - amt_c;
                end
            end
            CMD_KEEP:
            begin
                step = count_reg - amt_c;
                if (too_many)
                begin
                    status_next = STS_REFUSED;
                end
                else
                begin
                    head_next  = head_step;
                    count_next = amt_c;
                end
            end
            default:
            begin
                step = '0;
            end
        endcase
    end

    // latch the beat and read the head entry in the same edge
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg     <= command;
            elem_reg    <= element_data[ELEMENT_BITS-1:0];
            amt_reg     <= amount;
            rd_data_reg <= mem[head_reg];
        end
        if (ctrl.commit && wr_en)
        begin
            mem[wr_addr] <= elem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg  <= status_next;
            rdata_reg   <= rdata_next;
            matched_reg <= matched_next;
            fill_reg    <= count_next;
            empty_reg   <= (count_next == '0);
            full_reg    <= (count_next == CW'(DEPTH));
        end
    end

    assign fill_ext   = OUTW'(fill_reg);
    assign status     = status_reg;
    assign read_data  = DATA_BITS'(rdata_reg);
    assign matched    = matched_reg;
    assign fill_level = fill_ext[FILL_BITS-1:0];
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

endmodule

>>> hw/rtl/overwriting_ring_buffer.sv
// Each accepted input beat reads the head entry from the single-port store
// in the accept cycle and commits once the output register is free; a new
// beat is taken only after the previous command has committed.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n low, asynchronous): head and fill count go to zero, no result
// is pending; the entry store is not cleared and needs no clearing pass.
module overwriting_ring_buffer
    import orb_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_BITS-1:0]    command,
    input  logic [DATA_BITS-1:0]   element_data,
    input  logic [AMOUNT_BITS-1:0] amount,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_BITS-1:0] status,
    output logic [DATA_BITS-1:0]   read_data,
    output logic                   matched,
    output logic [FILL_BITS-1:0]   fill_level,
    output logic                   is_empty,
    output logic                   is_full
);

    // Command bus from the controller to the datapath.
    orb_cmd_t ctrl;

    // Controller: take a beat in idle, then commit once the output register
    // is free (empty, or being drained by out_ready in the same cycle).
    orb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // Datapath: entry store, head and fill count, the shared wrap adder and
    // the result register. Put writes at head plus count; a full put advances
    // the head over the overwritten oldest entry.
    orb_datapath #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .command      (command),
        .element_data (element_data),
        .amount       (amount),
        .status       (status),
        .read_data    (read_data),
        .matched      (matched),
        .fill_level   (fill_level),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule
